FILE: hdl/tspf_pkg.sv
`default_nettype none

package tspf_pkg;

	// Stream geometry.
	localparam int PACKET_BYTES  = 188;
	localparam int FILTER_SLOTS  = 4;
	localparam int POS_BITS      = 48;
	localparam int COUNT_BITS    = 8;
	localparam int PID_BITS      = 13;
	localparam int SLOT_BITS     = PID_BITS + 1;
	localparam int CFG_IDX_BITS  = 8;

	localparam logic [7:0] SYNC_BYTE = 8'h47;

	// Longest adaptation field that still fits in a packet.
	localparam logic [7:0] MAX_ADAPT_LEN = 8'(PACKET_BYTES - 5);

	// Byte offsets within a packet.
	localparam logic [COUNT_BITS-1:0] OFS_SYNC      = COUNT_BITS'(0);
	localparam logic [COUNT_BITS-1:0] OFS_PID_HI    = COUNT_BITS'(1);
	localparam logic [COUNT_BITS-1:0] OFS_PID_LO    = COUNT_BITS'(2);
	localparam logic [COUNT_BITS-1:0] OFS_CTRL      = COUNT_BITS'(3);
	localparam logic [COUNT_BITS-1:0] OFS_ADAPT_LEN = COUNT_BITS'(4);
	localparam logic [COUNT_BITS-1:0] OFS_LAST      = COUNT_BITS'(PACKET_BYTES - 1);

	// Adaptation field control codes.
	localparam logic [1:0] AFC_RESERVED      = 2'd0;
	localparam logic [1:0] AFC_PAYLOAD_ONLY  = 2'd1;
	localparam logic [1:0] AFC_ADAPT_ONLY    = 2'd2;
	localparam logic [1:0] AFC_ADAPT_PAYLOAD = 2'd3;

	typedef logic [FILTER_SLOTS-1:0][SLOT_BITS-1:0] tspf_slots_t;

	// One result item as it leaves the parser.
	typedef struct packed {
		logic [7:0]              payload_byte;
		logic [FILTER_SLOTS-1:0] filter_hits;
		logic                    unit_start;
		logic                    first_of_payload;
		logic                    last_of_payload;
		logic [PID_BITS-1:0]     packet_id;
		logic [POS_BITS-1:0]     byte_position;
		logic                    sync_error;
		logic                    length_error;
	} tspf_result_t;

endpackage

`default_nettype wire

FILE: hdl/tspf_cfg_regs.sv
`default_nettype none

module tspf_cfg_regs
	import tspf_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_valid,
	input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [SLOT_BITS-1:0]    cfg_data,
	output      tspf_slots_t             slots
);

	tspf_slots_t slot_q;

	// Filter slot registers; writes beyond the last slot are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (cfg_valid) begin
			for (int i = 0; i < FILTER_SLOTS; i++) begin
				if (cfg_index == CFG_IDX_BITS'(i)) begin
					slot_q[i] <= cfg_data;
				end
			end
		end
	end

	assign slots = slot_q;

endmodule

`default_nettype wire

FILE: hdl/tspf_parser.sv
`default_nettype none

module tspf_parser
	import tspf_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         fire,
	input  wire logic [7:0]   stream_byte,
	input  wire tspf_slots_t  slots,
	output      logic         emit,
	output      tspf_result_t res
);

	logic [COUNT_BITS-1:0]   count_q, count_d;
	logic [PID_BITS-1:0]     id_q, id_d;
	logic                    start_q, start_d;
	logic [1:0]              fc_q, fc_d;
	logic [7:0]              skip_q, skip_d;
	logic [POS_BITS-1:0]     pos_q;
	logic [FILTER_SLOTS-1:0] hit_q, hit_d;
	logic                    drop_q, drop_d;

	logic                    adapt;
	logic                    len_bad;
	logic [8:0]              payload_start;

	assign adapt = (fc_q == AFC_ADAPT_ONLY) || (fc_q == AFC_ADAPT_PAYLOAD);
	assign len_bad = (stream_byte > MAX_ADAPT_LEN) ||
		((fc_q == AFC_ADAPT_ONLY) && (stream_byte != MAX_ADAPT_LEN));
	assign payload_start = adapt ? (9'd5 + {1'b0, skip_q}) : 9'd4;

	// Header parse and payload selection for the byte at hand.
	always_comb begin
		count_d = (count_q == OFS_LAST) ? '0 : count_q + 1'b1;
		id_d    = id_q;
		start_d = start_q;
		fc_d    = fc_q;
		skip_d  = skip_q;
		hit_d   = hit_q;
		drop_d  = drop_q;
		emit    = 1'b0;
		res     = '0;
		res.payload_byte  = stream_byte;
		res.byte_position = pos_q;

		if (count_q == OFS_SYNC) begin
			id_d    = '0;
			start_d = 1'b0;
			fc_d    = AFC_RESERVED;
			skip_d  = '0;
			hit_d   = '0;
			drop_d  = 1'b0;
			if (stream_byte != SYNC_BYTE) begin
				drop_d         = 1'b1;
				emit           = 1'b1;
				res.sync_error = 1'b1;
			end
		end else if (!drop_q) begin
			priority if (count_q == OFS_PID_HI) begin
				start_d = stream_byte[6];
				id_d    = {stream_byte[4:0], 8'h00};
			end else if (count_q == OFS_PID_LO) begin
				id_d = {id_q[PID_BITS-1:8], stream_byte};
				for (int i = 0; i < FILTER_SLOTS; i++) begin
					hit_d[i] = slots[i][PID_BITS] && (slots[i][PID_BITS-1:0] == id_d);
				end
			end else if (count_q == OFS_CTRL) begin
				fc_d   = stream_byte[5:4];
				skip_d = '0;
			end else if (adapt && (count_q == OFS_ADAPT_LEN)) begin
				skip_d = stream_byte;
				if (len_bad) begin
					drop_d           = 1'b1;
					emit             = 1'b1;
					res.length_error = 1'b1;
				end
			end else begin
				if ((fc_q != AFC_ADAPT_ONLY) && ({1'b0, count_q} >= payload_start) &&
					(hit_q != '0)) begin
					emit                 = 1'b1;
					res.filter_hits      = hit_q;
					res.unit_start       = start_q;
					res.first_of_payload = ({1'b0, count_q} == payload_start);
					res.last_of_payload  = (count_q == OFS_LAST);
					res.packet_id        = id_q;
				end
			end
		end
	end

	// Packet state advances once per processed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			id_q    <= '0;
			start_q <= 1'b0;
			fc_q    <= AFC_RESERVED;
			skip_q  <= '0;
			pos_q   <= '0;
			hit_q   <= '0;
			drop_q  <= 1'b0;
		end else if (fire) begin
			count_q <= count_d;
			id_q    <= id_d;
			start_q <= start_d;
			fc_q    <= fc_d;
			skip_q  <= skip_d;
			pos_q   <= pos_q + 1'b1;
			hit_q   <= hit_d;
			drop_q  <= drop_d;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/ts_pid_payload_filter_core.sv
// Transport stream packet id filter, one stream byte per item.
// Input channel: in_valid, in_stall, stream_byte. A byte is taken at a rising
// edge with in_valid high and in_stall low. Bytes form 188-byte packets; the
// first byte after reset is taken as a sync byte.
// Output channel: out_valid, out_stall and the result fields. Only payload
// bytes of packets whose id hits an enabled slot produce an item, plus one
// error item for a bad sync byte or a bad adaptation field length.
// Configuration: cfg_valid, cfg_ready (always high), cfg_index, cfg_data.
// Slot i is written at index i; other indexes are ignored. Write only while
// the stream is idle.
// A byte taken is held in the input register, parsed, and its result held in
// the output register, which drives the outputs.
// Throughput is one byte per cycle while the output is not stalled, set by
// the single parse stage between the input register and the output register.
// When out_stall is held with a result waiting, at most one more byte is
// taken into the input register; while it holds a byte, in_stall follows
// out_stall in the same cycle. Nothing is lost.
// Reset clears the slots, the packet parser and the stream position.
`default_nettype none

module ts_pid_payload_filter_core
	import tspf_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output      logic                    in_stall,
	input  wire logic [7:0]              stream_byte,
	output      logic                    out_valid,
	input  wire logic                    out_stall,
	output      logic [7:0]              payload_byte,
	output      logic [FILTER_SLOTS-1:0] filter_hits,
	output      logic                    unit_start,
	output      logic                    first_of_payload,
	output      logic                    last_of_payload,
	output      logic [PID_BITS-1:0]     packet_id,
	output      logic [POS_BITS-1:0]     byte_position,
	output      logic                    sync_error,
	output      logic                    length_error,
	input  wire logic                    cfg_valid,
	output      logic                    cfg_ready,
	input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [SLOT_BITS-1:0]    cfg_data
);

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         out_valid_s2;
	tspf_result_t res_s2;
	tspf_result_t res;
	tspf_slots_t  slots;
	logic         advance;
	logic         fire;
	logic         accept;
	logic         emit;

	assign cfg_ready = 1'b1;

	// The pipeline moves whenever the output register is free or being taken.
	assign advance  = !out_valid_s2 || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	tspf_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.slots     (slots)
	);

	tspf_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.stream_byte (byte_s1),
		.slots       (slots),
		.emit        (emit),
		.res         (res)
	);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= stream_byte;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid        = out_valid_s2;
	assign payload_byte     = res_s2.payload_byte;
	assign filter_hits      = res_s2.filter_hits;
	assign unit_start       = res_s2.unit_start;
	assign first_of_payload = res_s2.first_of_payload;
	assign last_of_payload  = res_s2.last_of_payload;
	assign packet_id        = res_s2.packet_id;
	assign byte_position    = res_s2.byte_position;
	assign sync_error       = res_s2.sync_error;
	assign length_error     = res_s2.length_error;

	// Error items carry no filter information.
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (sync_error || length_error) |->
			(filter_hits == '0) && !first_of_payload && !last_of_payload &&
			!(sync_error && length_error))
		else $error("error item carries payload fields");

	// A payload item always names at least one slot.
	a_payload_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !sync_error && !length_error |-> (filter_hits != '0))
		else $error("payload item with empty hit mask");

	// Backpressure reaches the input only when the input register is full.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_s2 && out_stall)
		else $error("input stalled with room in the pipeline");

	// A stalled result is held until taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(byte_position))
		else $error("stalled result changed");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import tspf_pkg::*;

	localparam int SETTLE_CYCLES     = 4;
	localparam int END_SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES       = 64;
	localparam int WATCHDOG_LIMIT    = 2000;
	localparam int PHASES            = 2;
	localparam int PACKETS_PER_PHASE = 1;

	localparam logic       SLOT_ON      = 1'b1;
	localparam logic       SLOT_OFF     = 1'b0;
	localparam logic [8:0] FILL_RANDOM  = 9'h100;
	localparam shortint    BY_PREDICTOR = -1;

	typedef enum logic [1:0] {FAULT_NONE, FAULT_SYNC, FAULT_LENGTH} fault_t;

	// One directed packet: header fields, payload fill, and what it should give.
	typedef struct packed {
		logic [7:0]          sync;
		logic                pusi;
		logic [PID_BITS-1:0] pid;
		logic [1:0]          afc;
		logic [7:0]          adapt_len;
		logic [8:0]          fill;
		logic                load_cfg;
		shortint             want_items;
		fault_t              fault;
	} pkt_row_t;

	// Slot 0 passes id 0, slots 1 and 2 both pass id 0x1fff, slot 3 is off.
	localparam tspf_slots_t DIRECTED_SLOTS = {
		{SLOT_OFF, 13'h0100}, {SLOT_ON, 13'h1fff}, {SLOT_ON, 13'h1fff}, {SLOT_ON, 13'h0000}
	};

	// Extremes of the slot word: all ones, all zeros.
	localparam tspf_slots_t EXTREME_SLOTS = {
		{SLOT_ON, 13'h0000}, {SLOT_OFF, 13'h0000}, {SLOT_ON, 13'h1fff}, {SLOT_ON, 13'h1fff}
	};

	localparam pkt_row_t DIRECTED_ROWS [5] = '{
		// All slots are off after reset, so even id 0 passes nothing.
		'{8'h47, 1'b0, 13'h0000, AFC_PAYLOAD_ONLY, 8'd0, FILL_RANDOM, 1'b0, 0, FAULT_NONE},
		'{8'h47, 1'b1, 13'h0000, AFC_PAYLOAD_ONLY, 8'd0, 9'h000, 1'b1, 184, FAULT_NONE},
		'{8'hff, 1'b1, 13'h1fff, AFC_PAYLOAD_ONLY, 8'd0, FILL_RANDOM, 1'b0, 1, FAULT_SYNC},
		'{8'h47, 1'b0, 13'h0100, AFC_ADAPT_ONLY, 8'd182, FILL_RANDOM, 1'b0, 1, FAULT_LENGTH},
		'{8'h47, 1'b0, 13'h1fff, AFC_ADAPT_PAYLOAD, 8'd182, FILL_RANDOM, 1'b0, BY_PREDICTOR,
			FAULT_NONE}
	};

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [7:0]              stream_byte = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [7:0]              payload_byte;
	logic [FILTER_SLOTS-1:0] filter_hits;
	logic                    unit_start;
	logic                    first_of_payload;
	logic                    last_of_payload;
	logic [PID_BITS-1:0]     packet_id;
	logic [POS_BITS-1:0]     byte_position;
	logic                    sync_error;
	logic                    length_error;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [SLOT_BITS-1:0]    cfg_data = '0;

	// Shadow of the slots and of the packet parser, all zero out of reset.
	tspf_slots_t             slot_cfg = '0;
	logic [COUNT_BITS-1:0]   pkt_offset = '0;
	logic [PID_BITS-1:0]     pkt_id = '0;
	logic                    pkt_start = 1'b0;
	logic [1:0]              pkt_afc = AFC_RESERVED;
	logic [7:0]              pkt_adapt_len = '0;
	logic [POS_BITS-1:0]     stream_pos = '0;
	logic [FILTER_SLOTS-1:0] pkt_hits = '0;
	logic                    pkt_dropped = 1'b0;

	tspf_result_t            pending_results[$];

	int  fail_count = 0;
	int  bytes_sent = 0;
	int  packets_sent = 0;
	int  slot_writes = 0;
	int  items_seen = 0;
	int  sync_seen = 0;
	int  len_seen = 0;
	bit  no_idle = 1'b0;
	bit  hold_request = 1'b0;

	ts_pid_payload_filter_core dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.stream_byte      (stream_byte),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.payload_byte     (payload_byte),
		.filter_hits      (filter_hits),
		.unit_start       (unit_start),
		.first_of_payload (first_of_payload),
		.last_of_payload  (last_of_payload),
		.packet_id        (packet_id),
		.byte_position    (byte_position),
		.sync_error       (sync_error),
		.length_error     (length_error),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always #5 clk = ~clk;

	// Append one expected item at the tail of the queue.
	task automatic expect_item(input tspf_result_t r);
		pending_results.insert(pending_results.size(), r);
	endtask

	// Advance the parser shadow by one stream byte and queue what it should emit.
	task automatic parse_stream_byte(input logic [7:0] b);
		logic [COUNT_BITS-1:0] ofs;
		logic [POS_BITS-1:0]   here;
		tspf_result_t          r;
		logic                  adapt;
		int                    first_ofs;
		ofs = pkt_offset;
		here = stream_pos;
		r = '0;
		r.payload_byte = b;
		r.byte_position = here;
		stream_pos = stream_pos + 1'b1;
		pkt_offset = (ofs == OFS_LAST) ? OFS_SYNC : ofs + 1'b1;
		if (ofs == OFS_SYNC) begin
			pkt_dropped = 1'b0;
			pkt_hits = '0;
			pkt_id = '0;
			pkt_start = 1'b0;
			pkt_afc = AFC_RESERVED;
			pkt_adapt_len = '0;
			if (b != SYNC_BYTE) begin
				pkt_dropped = 1'b1;
				r.sync_error = 1'b1;
				expect_item(r);
			end
		end else if (!pkt_dropped) begin
			case (ofs)
				OFS_PID_HI: begin
					pkt_start = b[6];
					pkt_id = {b[4:0], 8'h00};
				end
				OFS_PID_LO: begin
					pkt_id[7:0] = b;
					// The hit mask is frozen here for the rest of the packet.
					pkt_hits = '0;
					for (int i = 0; i < FILTER_SLOTS; i++)
						if (slot_cfg[i][PID_BITS] && slot_cfg[i][PID_BITS-1:0] == pkt_id)
							pkt_hits[i] = 1'b1;
				end
				OFS_CTRL: begin
					pkt_afc = b[5:4];
					pkt_adapt_len = '0;
				end
				default: begin
					adapt = (pkt_afc == AFC_ADAPT_ONLY) || (pkt_afc == AFC_ADAPT_PAYLOAD);
					if (adapt && ofs == OFS_ADAPT_LEN) begin
						pkt_adapt_len = b;
						// A field that overruns the packet, or an adaptation-only
						// packet whose field does not fill it, is an error.
						if (b > MAX_ADAPT_LEN ||
								(pkt_afc == AFC_ADAPT_ONLY && b != MAX_ADAPT_LEN)) begin
							pkt_dropped = 1'b1;
							r.length_error = 1'b1;
							expect_item(r);
						end
					end else begin
						first_ofs = adapt ? OFS_ADAPT_LEN + 1 + pkt_adapt_len : OFS_ADAPT_LEN;
						if (pkt_afc != AFC_ADAPT_ONLY && ofs >= first_ofs && pkt_hits != '0) begin
							r.filter_hits = pkt_hits;
							r.unit_start = pkt_start;
							r.first_of_payload = (ofs == first_ofs);
							r.last_of_payload = (ofs == OFS_LAST);
							r.packet_id = pkt_id;
							expect_item(r);
						end
					end
				end
			endcase
		end
	endtask

	task automatic cmp_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// Check each result item against the oldest expectation.
	task automatic check_result_item();
		tspf_result_t want;
		items_seen++;
		if (sync_error === 1'b1)
			sync_seen++;
		if (length_error === 1'b1)
			len_seen++;
		if (pending_results.size() == 0) begin
			$display("%0t: unexpected item, expected none, got byte %0h at position %0d",
				$time, payload_byte, byte_position);
			fail_count++;
		end else begin
			want = pending_results.pop_front();
			cmp_field("payload_byte", 64'(want.payload_byte), 64'(payload_byte));
			cmp_field("filter_hits", 64'(want.filter_hits), 64'(filter_hits));
			cmp_field("unit_start", 64'(want.unit_start), 64'(unit_start));
			cmp_field("first_of_payload", 64'(want.first_of_payload),
				64'(first_of_payload));
			cmp_field("last_of_payload", 64'(want.last_of_payload), 64'(last_of_payload));
			cmp_field("packet_id", 64'(want.packet_id), 64'(packet_id));
			cmp_field("byte_position", 64'(want.byte_position), 64'(byte_position));
			cmp_field("sync_error", 64'(want.sync_error), 64'(sync_error));
			cmp_field("length_error", 64'(want.length_error), 64'(length_error));
		end
	endtask

	// Both handshakes are observed with the values present before the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				check_result_item();
			if (in_valid && !in_stall)
				parse_stream_byte(stream_byte);
		end
	end

	// Receiver: random stalls, and a long hold-off when one is requested.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end
			out_stall <= !no_idle && ($urandom_range(99) < 9);
		end
	end

	// Watchdog: give up after a long run of cycles with no handshake at all.
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("tb_top: done, errors");
		$finish;
	end

	// Offer one stream byte, with a random idle gap first, and wait until taken.
	task automatic send_byte(input logic [7:0] b);
		while (!no_idle && $urandom_range(99) < 9) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		stream_byte <= b;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
	endtask

	task automatic send_packet(input logic [7:0] sync, input logic pusi,
			input logic [PID_BITS-1:0] pid, input logic [1:0] afc,
			input logic [7:0] adapt_len, input logic [8:0] fill);
		logic [7:0] noise;
		logic [7:0] b;
		noise = 8'($urandom);
		send_byte(sync);
		// Error, priority, scrambling and continuity bits carry random values.
		send_byte({noise[7], pusi, noise[5], pid[12:8]});
		send_byte(pid[7:0]);
		send_byte({noise[3:2], afc, noise[4:1]});
		for (int k = OFS_ADAPT_LEN; k < PACKET_BYTES; k++) begin
			if (k == OFS_ADAPT_LEN && (afc == AFC_ADAPT_ONLY || afc == AFC_ADAPT_PAYLOAD))
				b = adapt_len;
			else if (fill == FILL_RANDOM)
				b = 8'($urandom);
			else
				b = fill[7:0];
			send_byte(b);
		end
		packets_sent++;
	endtask

	// Mostly well-formed packets on configured ids, with some broken or pure noise.
	task automatic send_random_packet();
		int                  roll;
		logic [7:0]          sync;
		logic [PID_BITS-1:0] pid;
		logic [1:0]          afc;
		logic [7:0]          adapt_len;
		logic [SLOT_BITS-1:0] pick;
		roll = $urandom_range(99);
		if (roll < 5) begin
			for (int k = 0; k < PACKET_BYTES; k++)
				send_byte(8'($urandom));
			packets_sent++;
		end else begin
			sync = ($urandom_range(99) < 4) ? 8'($urandom) : SYNC_BYTE;
			pick = slot_cfg[$urandom_range(FILTER_SLOTS - 1)];
			pid = ($urandom_range(99) < 75) ? pick[PID_BITS-1:0] : PID_BITS'($urandom);
			roll = $urandom_range(99);
			afc = (roll < 15) ? AFC_RESERVED : (roll < 55) ? AFC_PAYLOAD_ONLY :
				(roll < 65) ? AFC_ADAPT_ONLY : AFC_ADAPT_PAYLOAD;
			roll = $urandom_range(99);
			if (afc == AFC_ADAPT_ONLY)
				adapt_len = (roll < 80) ? MAX_ADAPT_LEN : 8'($urandom);
			else if (roll < 80)
				adapt_len = 8'($urandom_range(MAX_ADAPT_LEN));
			else if (roll < 90)
				adapt_len = MAX_ADAPT_LEN - 8'($urandom_range(1));
			else
				adapt_len = 8'($urandom_range(255, MAX_ADAPT_LEN + 1));
			send_packet(sync, 1'($urandom), pid, afc, adapt_len, FILL_RANDOM);
		end
	endtask

	// Stop offering bytes and wait for every expected item, then a few more cycles.
	task automatic wait_idle(input int settle);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// Write all four slots, then two indexes that the block must ignore.
	task automatic program_slots(input tspf_slots_t vals);
		logic [CFG_IDX_BITS-1:0] idx;
		for (int i = 0; i < FILTER_SLOTS + 2; i++) begin
			idx = (i < FILTER_SLOTS) ? CFG_IDX_BITS'(i) :
				(i == FILTER_SLOTS) ? CFG_IDX_BITS'(FILTER_SLOTS) : '1;
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data <= (i < FILTER_SLOTS) ? vals[i] : SLOT_BITS'($urandom);
			do @(posedge clk); while (!cfg_ready);
			if (i < FILTER_SLOTS)
				slot_cfg[i] = vals[i];
			slot_writes++;
		end
		cfg_valid <= 1'b0;
	endtask

	initial begin
		pkt_row_t    row;
		tspf_slots_t vals;
		int          base_items;
		int          base_sync;
		int          base_len;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed packets: each starts from an empty pipeline.
		for (int r = 0; r < $size(DIRECTED_ROWS); r++) begin
			row = DIRECTED_ROWS[r];
			wait_idle(SETTLE_CYCLES);
			if (row.load_cfg)
				program_slots(DIRECTED_SLOTS);
			base_items = items_seen;
			base_sync = sync_seen;
			base_len = len_seen;
			send_packet(row.sync, row.pusi, row.pid, row.afc, row.adapt_len, row.fill);
			if (row.want_items != BY_PREDICTOR) begin
				wait_idle(SETTLE_CYCLES);
				if (items_seen - base_items != row.want_items ||
						sync_seen - base_sync != int'(row.fault == FAULT_SYNC) ||
						len_seen - base_len != int'(row.fault == FAULT_LENGTH)) begin
					$display("%0t: packet %0d expected %0d items (%s), got %0d (%0d sync, %0d length)",
						$time, r, row.want_items, row.fault.name(), items_seen - base_items,
						sync_seen - base_sync, len_seen - base_len);
					fail_count++;
				end
			end
		end

		// Random packets under two slot settings; the pipeline drains between them.
		for (int ph = 0; ph < PHASES; ph++) begin
			for (int i = 0; i < FILTER_SLOTS; i++)
				vals[i] = (ph == 0) ? {($urandom_range(99) < 75) ? SLOT_ON : SLOT_OFF,
					PID_BITS'($urandom)} : SLOT_BITS'($urandom);
			if (ph == 1)
				vals = EXTREME_SLOTS;
			wait_idle(SETTLE_CYCLES);
			program_slots(vals);
			no_idle = (ph == PHASES - 1);
			if (ph == 1) begin
				// Hold the output while a fully matching packet streams in.
				hold_request = 1'b1;
				send_packet(SYNC_BYTE, 1'b1, slot_cfg[0][PID_BITS-1:0], AFC_PAYLOAD_ONLY,
					8'd0, FILL_RANDOM);
			end
			for (int p = 0; p < PACKETS_PER_PHASE; p++)
				send_random_packet();
		end
		no_idle = 1'b0;

		wait_idle(END_SETTLE_CYCLES);
		$display("summary: %0d stream bytes in %0d packets, %0d config writes",
			bytes_sent, packets_sent, slot_writes);
		$display("summary: %0d result items checked, %0d sync and %0d length errors among them",
			items_seen, sync_seen, len_seen);
		if (fail_count == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule
